### rtl/core/scwv_pkg.sv
// shared types, constants and the sine table builder for the contrast waveshaper
`default_nettype none
package scwv_pkg;

    localparam int SINE_TABLE_BITS = 10;
    localparam int SINE_ENTRIES    = 2 ** SINE_TABLE_BITS + 1;
    localparam int SINE_SHIFT      = 15 - SINE_TABLE_BITS;
    localparam int SINE_ADDR_W     = SINE_TABLE_BITS + 1;
    localparam int PHASE_W         = 17;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam logic [30:0]     INV_PI_Q32  = 31'd1367130551;

    // register indexes of the configuration port
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SHAPING_ENABLE = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CONTRAST_LEVEL = 1'd1;
    localparam int CFG_DATA_W = 16;

    typedef struct packed {
        logic signed [15:0] sample_in;
        logic               last_in;
    } s_payload_t;

    typedef struct packed {
        logic signed [15:0] sample_out;
        logic               last_out;
    } m_payload_t;

    // quarter-wave sine entry in q15, nine-term taylor series in q30
    function automatic logic [15:0] sine_entry(input int i);
        longint unsigned theta;
        longint unsigned theta2;
        longint unsigned term;
        longint          sum;
        theta  = (HALF_PI_Q30 * 64'(i)) >> SINE_TABLE_BITS;
        theta2 = (theta * theta) >> 30;
        term   = theta;
        sum    = longint'(term);
        for (int k = 1; k <= 8; k++) begin
            term = (term * theta2) >> 30;
            case (k)
                1:       term = term / 6;
                2:       term = term / 20;
                3:       term = term / 42;
                4:       term = term / 72;
                5:       term = term / 110;
                6:       term = term / 156;
                7:       term = term / 210;
                8:       term = term / 272;
                default: term = term;
            endcase
            if (k % 2 == 1) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        sum = longint'((unsigned'(sum) + 64'd16384) >> 15);
        if (sum > 32768) begin
            sum = 32768;
        end
        return sum[15:0];
    endfunction

endpackage
`default_nettype wire

### rtl/core/scwv_sine.sv
// three-stage full-circle sine: quadrant fold, table read, interpolate and sign
`default_nettype none
module scwv_sine
    import scwv_pkg::*;
(
    input  wire logic                      aclk,
    input  wire logic [2:0]                stage_en,
    input  wire logic [PHASE_W-1:0]        phase,
    output logic signed [PHASE_W-1:0]      sine
);

    localparam logic [SINE_ADDR_W-1:0] TOP_ADDR = SINE_ADDR_W'(2 ** SINE_TABLE_BITS);

    logic [15:0]            sine_rom [SINE_ENTRIES];

    logic [1:0]             quad;
    logic [15:0]            fold;
    logic [SINE_ADDR_W-1:0] addr_a_next;
    logic [SINE_ADDR_W-1:0] addr_b_next;

    logic [SINE_ADDR_W-1:0] addr_a_reg;
    logic [SINE_ADDR_W-1:0] addr_b_reg;
    logic [SINE_SHIFT-1:0]  frac1_reg;
    logic                   neg1_reg;

    logic [15:0]            a_reg;
    logic [15:0]            b_reg;
    logic [SINE_SHIFT-1:0]  frac2_reg;
    logic                   neg2_reg;

    logic signed [16:0]     diff;
    logic [15:0]            diff_pos;
    logic [15+SINE_SHIFT:0] interp;
    logic [16:0]            mag;
    logic signed [PHASE_W-1:0] sine_next;
    logic signed [PHASE_W-1:0] sine_reg;

    // constant quarter-wave table
    for (genvar g = 0; g < SINE_ENTRIES; g++) begin : g_rom
        localparam logic [15:0] ENTRY = sine_entry(g);
        assign sine_rom[g] = ENTRY;
    end

    // odd quadrants mirror around the quarter point
    always_comb begin
        quad        = phase[16:15];
        fold        = quad[0] ? (16'd32768 - {1'b0, phase[14:0]}) : {1'b0, phase[14:0]};
        addr_a_next = fold[15:SINE_SHIFT];
        addr_b_next = (addr_a_next == TOP_ADDR) ? addr_a_next : addr_a_next + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            addr_a_reg <= addr_a_next;
            addr_b_reg <= addr_b_next;
            frac1_reg  <= fold[SINE_SHIFT-1:0];
            neg1_reg   <= quad[1];
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            a_reg     <= sine_rom[addr_a_reg];
            b_reg     <= sine_rom[addr_b_reg];
            frac2_reg <= frac1_reg;
            neg2_reg  <= neg1_reg;
        end
    end

    always_comb begin
        diff      = $signed({1'b0, b_reg}) - $signed({1'b0, a_reg});
        diff_pos  = diff[16] ? 16'd0 : diff[15:0];
        interp    = diff_pos * frac2_reg;
        mag       = {1'b0, a_reg} + {1'b0, interp[15+SINE_SHIFT:SINE_SHIFT]};
        sine_next = neg2_reg ? $signed(17'd0 - mag) : $signed(mag);
    end

    always_ff @(posedge aclk) begin
        if (stage_en[2]) begin
            sine_reg <= sine_next;
        end
    end

    assign sine = sine_reg;

endmodule
`default_nettype wire

### rtl/core/sine_contrast_waveshaper_unit.sv
// top level of the contrast waveshaper: config registers and eleven-stage pipeline
//
//  channel   dir  handshake            payload
//  s_        in   s_valid / s_ready    s_payload_t  (sample_in, last_in)
//  m_        out  m_valid / m_ready    m_payload_t  (sample_out, last_out)
//  cfg_      in   cfg_wr_en            cfg_index, cfg_wr_data
//
// one sample a cycle sustained while m_ready is high; stages are an input register,
// two three-stage table sines, the offset multiply chain between them, the output.
// aresetn (synchronous) clears the config registers and every stage valid bit.
// each stage holds only while it is full and the one after it holds, so bubbles
// are squeezed out and a stalled m_ready still lets the input side fill up.
`default_nettype none
module sine_contrast_waveshaper_unit
    import scwv_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire s_payload_t             s_payload,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output m_payload_t                  m_payload,
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wr_data
);

    localparam int STAGES = 11;

    logic        shaping_enable_reg;
    logic [15:0] contrast_level_reg;

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] stage_en;
    s_payload_t        side_reg [STAGES];

    logic signed [PHASE_W-1:0] s1;
    logic signed [PHASE_W-1:0] s2;
    logic [PHASE_W-1:0]        phase1;

    logic [16:0] abs1_full;
    logic [31:0] mag_full;
    logic [30:0] mag_reg;
    logic        neg4_reg;

    logic [61:0] off_prod;
    logic [14:0] offm_reg;
    logic        neg5_reg;

    logic [PHASE_W-1:0] off_signed;
    logic [PHASE_W-1:0] phase2_next;
    logic [PHASE_W-1:0] phase2_reg;

    logic [16:0] abs2_full;
    logic [30:0] out_prod;
    logic [15:0] shaped;
    logic [15:0] sample_next;
    logic [15:0] sample_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shaping_enable_reg <= 1'b0;
            contrast_level_reg <= 16'd0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_SHAPING_ENABLE: shaping_enable_reg <= cfg_wr_data[0];
                CFG_CONTRAST_LEVEL: contrast_level_reg <= cfg_wr_data[15:0];
            endcase
        end
    end

    // a stage loads when it is empty or the next one loads too
    always_comb begin
        stage_en[STAGES-1] = !valid_reg[STAGES-1] || m_ready;
        for (int i = STAGES - 2; i >= 0; i--) begin
            stage_en[i] = !valid_reg[i] || stage_en[i+1];
        end
    end

    assign s_ready = stage_en[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (stage_en[0]) begin
                valid_reg[0] <= s_valid;
            end
            for (int i = 1; i < STAGES; i++) begin
                if (stage_en[i]) begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            side_reg[0] <= s_payload;
        end
        for (int i = 1; i < STAGES; i++) begin
            if (stage_en[i]) begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // inner sine runs at phase 4x, stages 1 to 3
    assign phase1 = {side_reg[0].sample_in[14:0], 2'b00};

    scwv_sine u_sine_inner (
        .aclk     (aclk),
        .stage_en (stage_en[3:1]),
        .phase    (phase1),
        .sine     (s1)
    );

    // stage 4: level times magnitude of the inner sine
    always_comb begin
        abs1_full = s1[16] ? 17'd0 - s1 : s1;
        mag_full  = contrast_level_reg * abs1_full[15:0];
    end

    always_ff @(posedge aclk) begin
        if (stage_en[4]) begin
            mag_reg  <= mag_full[30:0];
            neg4_reg <= s1[16];
        end
    end

    // stage 5: scale by 1/pi into phase units, truncated toward zero
    assign off_prod = mag_reg * INV_PI_Q32;

    always_ff @(posedge aclk) begin
        if (stage_en[5]) begin
            offm_reg <= off_prod[61:47];
            neg5_reg <= neg4_reg;
        end
    end

    // stage 6: outer phase, wraps modulo the full circle
    always_comb begin
        off_signed  = neg5_reg ? 17'd0 - {2'b00, offm_reg} : {2'b00, offm_reg};
        phase2_next = {side_reg[5].sample_in[15], side_reg[5].sample_in} + off_signed;
    end

    always_ff @(posedge aclk) begin
        if (stage_en[6]) begin
            phase2_reg <= phase2_next;
        end
    end

    // outer sine, stages 7 to 9
    scwv_sine u_sine_outer (
        .aclk     (aclk),
        .stage_en (stage_en[9:7]),
        .phase    (phase2_reg),
        .sine     (s2)
    );

    // stage 10: scale q15 to 32767 full scale, sign applied; bypass when shaping is off
    always_comb begin
        abs2_full   = s2[16] ? 17'd0 - s2 : s2;
        out_prod    = abs2_full[15:0] * 15'd32767;
        shaped      = s2[16] ? 16'd0 - out_prod[30:15] : out_prod[30:15];
        sample_next = shaping_enable_reg ? shaped : side_reg[9].sample_in;
    end

    always_ff @(posedge aclk) begin
        if (stage_en[10]) begin
            sample_reg <= sample_next;
        end
    end

    assign m_valid = valid_reg[STAGES-1];

    always_comb begin
        m_payload.sample_out = $signed(sample_reg);
        m_payload.last_out   = side_reg[STAGES-1].last_in;
    end

endmodule
`default_nettype wire
